>>> src/grr_pkg.sv
// Shared types and constants for the group reversal reorder block.
package grr_pkg;

    // Width of the group size register.
    localparam int CFG_W = 5;

    // Width of one list element.
    localparam int DATA_W = 32;

    // Flags that travel with each closed group from front to back.
    typedef struct packed {
        logic bank;   // buffer bank that holds the group
        logic rev;    // 1: emit newest first, 0: emit in arrival order
        logic fin;    // group closes the list
    } grp_flags_t;

endpackage

>>> src/grr_front.sv
// Front end: accepts words, writes them to the group buffer and closes groups.
module grr_front #(
    parameter int MAX_GROUP = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [grr_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [grr_pkg::DATA_W-1:0]    value,
    input  logic                          last,
    output logic                          wr_en,
    output logic [$clog2(MAX_GROUP):0]    wr_addr,
    output logic [grr_pkg::DATA_W-1:0]    wr_data,
    output logic                          push,
    output grr_pkg::grp_flags_t           push_flags,
    output logic [$clog2(MAX_GROUP+1)-1:0] push_cnt,
    input  logic                          free_valid,
    input  logic                          free_bank
);
    import grr_pkg::*;

    localparam int AW   = $clog2(MAX_GROUP);
    localparam int CW   = $clog2(MAX_GROUP + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0] group_size_reg;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [CW-1:0]    cnt_inc;
    logic             accept;
    logic             size_hit;
    logic             close;

    // A bank is busy from the moment its group closes until the back end has read it.
    assign in_stall = busy_reg[bank_reg];
    assign accept   = in_valid && !in_stall;

    // Group closes on reaching the size (a size of zero closes at once), on a full bank,
    // or on the end of the list.
    assign cnt_inc  = fill_reg + CW'(1);
    assign size_hit = (CMPW'(cnt_inc) >= CMPW'(group_size_reg)) || (cnt_inc == CW'(MAX_GROUP));
    assign close    = size_hit || last;

    // Buffer write port.
    assign wr_en   = accept;
    assign wr_addr = {bank_reg, fill_reg[AW-1:0]};
    assign wr_data = value;

    // Descriptor of the closed group.
    assign push            = accept && close;
    assign push_flags.bank = bank_reg;
    assign push_flags.rev  = size_hit;
    assign push_flags.fin  = last;
    assign push_cnt        = cnt_inc;

    // Next-state logic for fill count, bank select and bank busy bits.
    always_comb
    begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (free_valid)
        begin
            busy_next[free_bank] = 1'b0;
        end
        if (accept)
        begin
            if (close)
            begin
                fill_next           = '0;
                bank_next           = !bank_reg;
                busy_next[bank_reg] = 1'b1;
            end
            else
            begin
                fill_next = cnt_inc;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= CFG_W'(1);
            fill_reg       <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                group_size_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

>>> src/grr_queue.sv
// Two-entry queue of closed-group descriptors between front and back.
module grr_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] din,
    input  logic          pop,
    output logic          not_empty,
    output logic [DW-1:0] dout
);
    logic [DW-1:0] entry_reg [2];
    logic          wptr_reg, wptr_next;
    logic          rptr_reg, rptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign not_empty = (cnt_reg != 2'd0);
    assign dout      = entry_reg[rptr_reg];
    assign do_push   = push && (cnt_reg != 2'd2);
    assign do_pop    = pop && not_empty;

    // Pointer and occupancy update.
    always_comb
    begin
        wptr_next = do_push ? !wptr_reg : wptr_reg;
        rptr_next = do_pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Descriptor storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= din;
        end
    end

endmodule

>>> src/grr_back.sv
// Back end: owns the two-bank group buffer and plays closed groups out.
module grr_back #(
    parameter int MAX_GROUP = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [$clog2(MAX_GROUP):0]     wr_addr,
    input  logic [grr_pkg::DATA_W-1:0]     wr_data,
    input  logic                           q_valid,
    input  grr_pkg::grp_flags_t            q_flags,
    input  logic [$clog2(MAX_GROUP+1)-1:0] q_cnt,
    output logic                           q_pop,
    output logic                           free_valid,
    output logic                           free_bank,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [grr_pkg::DATA_W-1:0]     value_res,
    output logic                           run_last,
    output logic                           stream_end
);
    import grr_pkg::*;

    localparam int AW    = $clog2(MAX_GROUP);
    localparam int CW    = $clog2(MAX_GROUP + 1);
    // Each bank spans the full address range of its AW index bits.
    localparam int DEPTH = 2 << AW;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     idx;
    logic              k_last;
    logic              issue;
    logic              move;

    logic              rd_valid_reg, rd_valid_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_last_reg;
    logic              rd_end_reg;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_end_reg;

    // Read stage hands its word on when the output register is empty or being taken.
    assign move  = rd_valid_reg && (!out_valid_reg || !out_stall);
    assign issue = q_valid && (!rd_valid_reg || move);

    // Element index within the group, newest first when reversing.
    assign k_last = (k_reg == q_cnt - CW'(1));
    assign idx    = q_flags.rev ? (q_cnt - CW'(1) - k_reg) : k_reg;

    // Last read of a group retires its descriptor and releases its bank.
    assign q_pop      = issue && k_last;
    assign free_valid = q_pop;
    assign free_bank  = q_flags.bank;

    always_comb
    begin
        k_next = k_reg;
        if (issue)
        begin
            k_next = k_last ? '0 : k_reg + CW'(1);
        end
        rd_valid_next  = issue || (rd_valid_reg && !move);
        out_valid_next = move || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Group buffer: one write port from the front, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[{q_flags.bank, idx[AW-1:0]}];
            rd_last_reg <= k_last;
            rd_end_reg  <= k_last && q_flags.fin;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= rd_last_reg;
            out_end_reg  <= rd_end_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_res  = out_data_reg;
    assign run_last   = out_last_reg;
    assign stream_end = out_end_reg;

endmodule

>>> src/group_reversal_reorder.sv
// Top level of the group reversal reorder block.
//
// Input words (value, last) arrive on in_valid/in_stall; reordered words leave on
// out_valid/out_stall with value_res, run_last and stream_end. A word moves when valid
// is high and stall is low. cfg_we/cfg_wdata write group_size; write it only while the
// block is idle. Each group of group_size words leaves newest first; a shorter group
// closed by last leaves in arrival order. run_last marks the final word of each group,
// stream_end the final word of the list.
// A group is read out once its closing word is taken, through the queue, the read
// register and the output register. Throughput: one word per cycle in and out,
// sustained. The buffer has two banks of MAX_GROUP words, so the front fills one
// group while the back plays out the previous one; in_stall rises only when both banks
// hold closed groups not yet read out, which sets the rate when the receiver stalls.
// A stalled output word holds; the back keeps one more word in its read stage.
// Reset clears group_size to 1 (pass-through), empties the buffer and the queue;
// no clearing pass is needed and words are taken on the first cycle after reset.
module group_reversal_reorder #(
    parameter int MAX_GROUP = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [grr_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [31:0]         value,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [31:0]         value_res,
    output logic                       run_last,
    output logic                       stream_end
);
    import grr_pkg::*;

    localparam int AW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int FW = $bits(grp_flags_t);
    localparam int QW = FW + CW;

    logic              wr_en;
    logic [AW:0]       wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              push;
    grp_flags_t        push_flags;
    logic [CW-1:0]     push_cnt;
    logic              q_valid;
    logic              q_pop;
    logic [QW-1:0]     q_dout;
    grp_flags_t        q_flags;
    logic [CW-1:0]     q_cnt;
    logic              free_valid;
    logic              free_bank;
    logic [DATA_W-1:0] res_data;

    grr_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last       (last),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push       (push),
        .push_flags (push_flags),
        .push_cnt   (push_cnt),
        .free_valid (free_valid),
        .free_bank  (free_bank)
    );

    grr_queue #(
        .DW (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       ({push_flags, push_cnt}),
        .pop       (q_pop),
        .not_empty (q_valid),
        .dout      (q_dout)
    );

    assign q_flags = q_dout[QW-1:CW];
    assign q_cnt   = q_dout[CW-1:0];

    grr_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .q_valid    (q_valid),
        .q_flags    (q_flags),
        .q_cnt      (q_cnt),
        .q_pop      (q_pop),
        .free_valid (free_valid),
        .free_bank  (free_bank),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_res  (res_data),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    assign value_res = res_data;

endmodule

>>> src/grr_checker.sv
// Port-level checks for the group reversal reorder block, bound to its top level.
module grr_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic signed [31:0]        value,
    input logic                      last,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [31:0]        value_res,
    input logic                      run_last,
    input logic                      stream_end
);

    // A stalled input word holds until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(value) && $stable(last))
        else $error("input word changed while stalled");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_res) && $stable(run_last)
            && $stable(stream_end))
        else $error("output word changed while stalled");

    // The end of the list always closes a group.
    a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> run_last)
        else $error("stream_end without run_last");

    // Inside a group the words follow each other without a gap.
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside an output group");

endmodule

bind group_reversal_reorder grr_checker u_grr_checker (.*);

>>> sim/grr_reorder_checker.sv
// Checker that predicts the reordered word stream and compares it with the block's output.
module grr_reorder_checker #(
    parameter int MAX_GROUP = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [grr_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [grr_pkg::DATA_W-1:0]  value,
    input  logic                               last,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [grr_pkg::DATA_W-1:0]  value_res,
    input  logic                               run_last,
    input  logic                               stream_end,
    output int                                 fail_count,
    output int                                 pending_words,
    output int                                 checked_words
);
    timeunit 1ns;
    timeprecision 1ps;

    import grr_pkg::*;

    // One reordered word as it should appear on the output channel.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     run_last;
        logic                     stream_end;
    } out_word_t;

    out_word_t          due_words[$];
    logic [CFG_W-1:0]   size_reg = 1;
    logic [DATA_W-1:0]  held[MAX_GROUP];
    int unsigned        held_count = 0;
    int                 fails = 0;
    int                 checked = 0;

    // Buffer one accepted word and queue every word that it releases.
    task automatic reorder_word(input logic [DATA_W-1:0] v, input logic end_flag);
        int unsigned eff;
        int unsigned n;
        int unsigned idx;
        bit          reverse;
        out_word_t   w;
        eff = (size_reg == 0) ? 1 : ((size_reg > MAX_GROUP) ? MAX_GROUP : size_reg);
        if (held_count < MAX_GROUP)
        begin
            held[held_count] = v;
            held_count++;
        end
        if (held_count < eff && !end_flag)
            return;
        // A full group leaves newest first, a short closing group in arrival order.
        reverse = (held_count >= eff);
        n = held_count;
        for (int unsigned k = 0; k < n; k++)
        begin
            idx = reverse ? (n - 1 - k) : k;
            w.value = held[idx];
            w.run_last = (k + 1 == n);
            w.stream_end = (k + 1 == n) && end_flag;
            due_words.push_back(w);
        end
        held_count = 0;
    endtask

    // Track configuration and input words, then check each output word in order.
    always @(posedge clk or negedge rst_n)
    begin : track
        out_word_t want;
        if (!rst_n)
        begin
            size_reg = 1;
            held_count = 0;
            due_words.delete();
        end
        else
        begin
            if (cfg_we)
                size_reg = cfg_wdata;
            if (in_valid && !in_stall)
                reorder_word(value, last);
            if (out_valid && !out_stall)
            begin
                checked++;
                if (due_words.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected word: value %0d run_last %0b stream_end %0b",
                                 $realtime, value_res, run_last, stream_end);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (value_res !== want.value || run_last !== want.run_last ||
                        stream_end !== want.stream_end)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch: expected value %0d run_last %0b ",
                                     $realtime, want.value, want.run_last,
                                     "stream_end %0b, got value %0d run_last %0b ",
                                     want.stream_end, value_res, run_last,
                                     "stream_end %0b", stream_end);
                    end
                end
            end
        end
        fail_count <= fails;
        pending_words <= due_words.size();
        checked_words <= checked;
    end

endmodule

>>> sim/tb_group_reversal_reorder.sv
// Testbench top for the group reversal reorder block: stimulus, idling and verdict.
module tb_group_reversal_reorder;
    timeunit 1ns;
    timeprecision 1ps;

    import grr_pkg::*;

    localparam int MAX_GROUP = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_WORDS = 10;
    localparam int PHASE_SIZES[12] = '{2, 3, 4, 5, 16, 0, 8, 17, 7, 1, 13, 6};

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_W-1:0]           cfg_wdata;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [DATA_W-1:0]   value;
    logic                       last;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [DATA_W-1:0]   value_res;
    logic                       run_last;
    logic                       stream_end;

    int fail_count;
    int pending_words;
    int checked_words;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int words_sent = 0;
    int quiet_cycles = 0;

    group_reversal_reorder #(.MAX_GROUP(MAX_GROUP)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_res  (value_res),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    grr_reorder_checker #(.MAX_GROUP(MAX_GROUP)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value_res     (value_res),
        .run_last      (run_last),
        .stream_end    (stream_end),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .checked_words (checked_words)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls at random according to the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
            $display("[group_reversal_reorder] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one word after a random idle gap and hold it until it is taken.
    task automatic put_word(input logic signed [DATA_W-1:0] v, input logic end_flag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        last <= end_flag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Send a list of n words; the final one carries the end flag if the list is closed.
    task automatic send_list(input int n, input bit closed);
        logic signed [DATA_W-1:0] v;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(7))
                0: v = 32'sh7FFF_FFFF;
                1: v = 32'sh8000_0000;
                default: v = $urandom;
            endcase
            put_word(v, closed && (i == n - 1));
        end
    endtask

    // Stop sending and wait until every predicted word has come out, plus a margin.
    task automatic drain_words();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the group size register; only the low bits of the setting are kept.
    task automatic write_size(input int s);
        cfg_we <= 1'b1;
        cfg_wdata <= CFG_W'(s);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus: directed cases first, then random phases over sizes and idle mixes.
    initial
    begin
        int eff;
        int n;
        int phase_words;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        value = '0;
        last = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size passes words straight through; value extremes first.
        put_word(32'sh7FFF_FFFF, 1'b0);
        put_word(32'sh8000_0000, 1'b1);
        drain_words();

        // A size of zero behaves as pass-through.
        write_size(0);
        put_word(-1, 1'b1);
        drain_words();

        // Oversized setting saturates to a full group that ends the list.
        write_size(31);
        for (int i = 0; i < MAX_GROUP; i++)
            put_word(i * 32'sh1111_1111 - 7, i == MAX_GROUP - 1);
        drain_words();

        // Shrink the size while three words wait: the next word closes all four.
        write_size(4);
        send_list(3, 1'b0);
        drain_words();
        write_size(2);
        put_word(32'sh0000_0004, 1'b0);
        drain_words();

        // A list shorter than the size leaves in order.
        write_size(5);
        send_list(3, 1'b1);
        drain_words();

        // Random phases, cycling through the four idle mixes.
        for (int p = 0; p < 12; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            write_size(PHASE_SIZES[p]);
            eff = (PHASE_SIZES[p] == 0) ? 1 :
                  ((PHASE_SIZES[p] > MAX_GROUP) ? MAX_GROUP : PHASE_SIZES[p]);
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                // Mostly lists spanning one to three groups, some no longer than a group.
                if ($urandom_range(3) == 0)
                    n = $urandom_range(eff, 1);
                else
                    n = $urandom_range(2 * eff + 1, eff);
                send_list(n, 1'b1);
                phase_words += n;
            end
            // Sometimes leave a group open so the next size change lands mid-group.
            if ($urandom_range(2) == 0)
                send_list($urandom_range(eff, 1), 1'b0);
            drain_words();
        end

        // Close whatever group is still open.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_list(1, 1'b1);
        drain_words();

        $display("Ran %0d input words over group sizes 0 to 31, mid-group size changes,",
                 words_sent);
        $display("and four sender/receiver idle mixes; %0d output words checked, %0d missing.",
                 checked_words, pending_words);
        if (fail_count == 0 && pending_words == 0)
            $display("[group_reversal_reorder] OK");
        else
            $display("[group_reversal_reorder] ERROR");
        $finish;
    end

endmodule
